FILE: src/nvd_pkg.sv
package nvd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 512;
    localparam int DEPTH_BITS   = 16;
    localparam int RADIUS_LIMIT = 15;

    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int D_W     = 16;
    localparam int IDX_W   = 19;
    localparam int CW_W    = 11;
    localparam int CH_W    = 10;
    localparam int CR_W    = 4;
    localparam int ADDR_W  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int Q_DEPTH = 4;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_SEARCH_RADIUS = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [X_W-1:0]  pixel_x;
        logic [Y_W-1:0]  pixel_y;
        logic [D_W-1:0]  depth_value;
    } nvd_in_t;

    typedef struct packed {
        logic             found;
        logic [X_W-1:0]   match_x;
        logic [Y_W-1:0]   match_y;
        logic [IDX_W-1:0] match_index;
        logic [D_W-1:0]   match_depth;
    } nvd_out_t;

    // queued work item, already classified
    typedef struct packed {
        logic                  is_query;
        logic [X_W-1:0]        x;
        logic [Y_W-1:0]        y;
        logic [DEPTH_BITS-1:0] depth;
    } nvd_entry_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [CW_W-1:0] width;
        logic [CH_W-1:0] height;
        logic [CR_W-1:0] radius;
    } nvd_cfg_t;

endpackage

FILE: src/nvd_queue.sv
module nvd_queue
    import nvd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  nvd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output nvd_entry_t pop_entry,
    output logic       empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    nvd_entry_t           slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == CNT_W'(Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/nvd_front.sv
module nvd_front
    import nvd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  nvd_in_t    s_data,
    output logic       q_push,
    output nvd_entry_t q_entry,
    input  logic       q_full
);

    logic       hold_valid_reg, hold_valid_next;
    nvd_entry_t entry_reg;
    logic       take;

    assign q_push  = hold_valid_reg && !q_full;
    assign q_entry = entry_reg;
    assign s_ready = !hold_valid_reg || !q_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (take) begin
            hold_valid_next = 1'b1;
        end else if (q_push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg.is_query <= (s_data.mode == MODE_QUERY);
            entry_reg.x        <= s_data.pixel_x;
            entry_reg.y        <= s_data.pixel_y;
            entry_reg.depth    <= DEPTH_BITS'(s_data.depth_value);
        end
    end

endmodule

FILE: src/nvd_back.sv
module nvd_back
    import nvd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  nvd_cfg_t   cfg,
    input  nvd_entry_t q_entry,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output nvd_out_t   m_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RING  = 5'b00010,
        ST_CAND  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_NONE  = 5'b10000
    } state_t;

    logic [DEPTH_BITS-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

    state_t                state_reg, state_next;
    logic [X_W-1:0]        cx_reg, cx_next;
    logic [Y_W-1:0]        cy_reg, cy_next;
    logic [CR_W-1:0]       r_reg, r_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [X_W-1:0]        xhi_reg, xhi_next;
    logic                  k_reg, k_next;
    logic [CR_W-1:0]       dy_reg, dy_next;
    logic [Y_W-1:0]        y_reg, y_next;
    logic [DEPTH_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    nvd_out_t              out_reg, out_next;

    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic                  out_free;
    logic                  do_adv, ring_next;
    logic [CR_W-1:0]       dy_cur;
    logic [X_W-1:0]        xlo, dx;
    logic [CW_W-1:0]       xsum, wm1, xhi_w;
    logic [CH_W-1:0]       y_wide;
    logic                  y_ok;
    logic [X_W+CW_W-1:0]   idx_full;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign wr_addr  = {q_entry.y, q_entry.x};
    assign rd_addr  = {y_wide[Y_W-1:0], x_reg};

    // ring bounds, clipped to the image
    always_comb begin
        xlo   = (cx_reg >= X_W'(r_reg)) ? X_W'(cx_reg - X_W'(r_reg)) : '0;
        xsum  = CW_W'(cx_reg) + CW_W'(r_reg);
        wm1   = CW_W'(cfg.width - 1'b1);
        xhi_w = (xsum > wm1) ? wm1 : xsum;
    end

    // candidate row for the current column
    always_comb begin
        dx = (x_reg >= cx_reg) ? X_W'(x_reg - cx_reg) : X_W'(cx_reg - x_reg);
        dy_cur = CR_W'(r_reg - dx[CR_W-1:0]);
        if (dx > X_W'(r_reg)) begin
            dy_cur = '0;
        end
        if (k_reg) begin
            y_wide = CH_W'(cy_reg) + CH_W'(dy_cur);
            y_ok   = (y_wide < cfg.height);
        end else begin
            y_wide = CH_W'(cy_reg) - CH_W'(dy_cur);
            y_ok   = (cy_reg >= Y_W'(dy_cur)) && (y_wide < cfg.height);
        end
    end

    assign idx_full = (X_W+CW_W)'(y_reg) * (X_W+CW_W)'(cfg.width) + (X_W+CW_W)'(x_reg);

    always_comb begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r_next         = r_reg;
        x_next         = x_reg;
        xhi_next       = xhi_reg;
        k_next         = k_reg;
        dy_next        = dy_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        do_adv         = 1'b0;
        ring_next      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (!q_entry.is_query) begin
                        wr_en = 1'b1;
                    end else begin
                        cx_next = q_entry.x;
                        cy_next = q_entry.y;
                        r_next  = '0;
                        if (cfg.width == '0 || cfg.height == '0) begin
                            state_next = ST_NONE;
                        end else begin
                            state_next = ST_RING;
                        end
                    end
                end
            end
            ST_RING: begin
                if (CW_W'(xlo) > xhi_w) begin
                    ring_next = 1'b1;
                end else begin
                    x_next     = xlo;
                    xhi_next   = xhi_w[X_W-1:0];
                    k_next     = 1'b0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                if (dx <= X_W'(r_reg) && y_ok) begin
                    rd_en      = 1'b1;
                    y_next     = y_wide[Y_W-1:0];
                    dy_next    = dy_cur;
                    state_next = ST_CHECK;
                end else begin
                    do_adv = 1'b1;
                end
            end
            ST_CHECK: begin
                if (rd_data_reg != '0) begin
                    if (x_reg == '0 && y_reg == '0) begin
                        // pixel at index zero is never taken: drop the rest of this ring
                        ring_next = 1'b1;
                    end else if (out_free) begin
                        out_valid_next       = 1'b1;
                        out_next.found       = 1'b1;
                        out_next.match_x     = x_reg;
                        out_next.match_y     = y_reg;
                        out_next.match_index = idx_full[IDX_W-1:0];
                        out_next.match_depth = D_W'(rd_data_reg);
                        state_next           = ST_IDLE;
                    end
                end else begin
                    do_adv = 1'b1;
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_adv) begin
            if (!k_reg && ((state_reg == ST_CHECK) ? dy_reg : dy_cur) != '0) begin
                k_next     = 1'b1;
                state_next = ST_CAND;
            end else if (x_reg == xhi_reg) begin
                ring_next = 1'b1;
            end else begin
                x_next     = X_W'(x_reg + 1'b1);
                k_next     = 1'b0;
                state_next = ST_CAND;
            end
        end

        if (ring_next) begin
            if (r_reg == cfg.radius) begin
                state_next = ST_NONE;
            end else begin
                r_next     = CR_W'(r_reg + 1'b1);
                state_next = ST_RING;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        r_reg   <= r_next;
        x_reg   <= x_next;
        xhi_reg <= xhi_next;
        k_reg   <= k_next;
        dy_reg  <= dy_next;
        y_reg   <= y_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= q_entry.depth;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: src/nearest_valid_depth_ring_search_core.sv
// Nearest valid depth pixel search over a frame store.
// s_ channel: one item per handshake. mode 0 stores depth_value at
// (pixel_x, pixel_y), depth 0 meaning invalid; mode 1 is a query centred
// on (pixel_x, pixel_y). Only queries give an item on the m_ channel.
// cfg_ channel: cfg_index selects image_width (0), image_height (1) or
// search_radius (2); write only while no query is in flight.
// Writes: one per cycle while the queue has room; the front register and a
// 4-deep queue let them queue up while the back end is busy.
// Queries: an accepted item passes the front register and the queue into the
// search, which visits RING for each ring, CAND for each candidate row in each
// column of the clip window and CHECK for each row probe inside the image; a
// miss passes through NONE before the result. One frame-store read port
// serialises the probes. Items are handled strictly in arrival order.
// Results sit in an output register; while m_ready is low the back end
// holds the finished query and the queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and output and loads
// 640 x 480 with radius 10. The frame store is not cleared; queries must
// only touch pixels written since power-up.
module nearest_valid_depth_ring_search_core
    import nvd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  nvd_in_t         s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output nvd_out_t        m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [CW_W-1:0] cfg_data
);

    logic [CW_W-1:0] width_reg;
    logic [CH_W-1:0] height_reg;
    logic [CR_W-1:0] radius_reg;
    nvd_cfg_t        cfg_eff;

    logic            q_push, q_full, q_pop, q_empty;
    nvd_entry_t      q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CW_W'(640);
            height_reg <= CH_W'(480);
            radius_reg <= CR_W'(10);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[CH_W-1:0];
                CFG_SEARCH_RADIUS: radius_reg <= cfg_data[CR_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate to the store geometry
    always_comb begin
        cfg_eff.width  = (width_reg > CW_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : width_reg;
        cfg_eff.height = (height_reg > CH_W'(MAX_HEIGHT)) ? CH_W'(MAX_HEIGHT) : height_reg;
        cfg_eff.radius = (CW_W'(radius_reg) > CW_W'(RADIUS_LIMIT)) ?
                         CR_W'(RADIUS_LIMIT) : radius_reg;
    end

    nvd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_entry (q_in),
        .q_full  (q_full)
    );

    nvd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    nvd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_eff),
        .q_entry (q_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.match_x == '0 && m_data.match_y == '0
            && m_data.match_index == '0 && m_data.match_depth == '0))
        else $error("miss result carries nonzero fields");

    a_no_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> !(m_data.match_x == '0 && m_data.match_y == '0))
        else $error("pixel at index zero returned");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");
`endif

endmodule

FILE: dv/nearest_valid_depth_ring_search_core_test.sv
module nearest_valid_depth_ring_search_core_test;
    import nvd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    nvd_in_t         s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    nvd_out_t        m_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = '0;
    logic [CW_W-1:0] cfg_data = '0;

    // mirror of the frame store: an entry exists once it has been written
    logic [D_W-1:0]  depth_mirror [int];
    logic [CW_W-1:0] reg_width = 11'd640;
    logic [CH_W-1:0] reg_height = 10'd480;
    logic [CR_W-1:0] reg_radius = 4'd10;

    nvd_out_t pending_matches [$];
    nvd_out_t want;
    int       mismatch_count = 0;
    bit       no_gaps = 1'b0;

    nearest_valid_depth_ring_search_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int clip_to(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    // first valid pixel over Manhattan rings, x ascending then y ascending
    function automatic nvd_out_t nearest_valid(int cx, int cy);
        nvd_out_t res;
        int w, h, rmax, r, x, y, k, dx, dy, xlo, xhi;
        logic [D_W-1:0] d;
        bit ring_skip;
        res = '0;
        w = clip_to(reg_width, MAX_WIDTH);
        h = clip_to(reg_height, MAX_HEIGHT);
        rmax = clip_to(reg_radius, RADIUS_LIMIT);
        if (w == 0 || h == 0) return res;
        for (r = 0; r <= rmax; r++) begin
            ring_skip = 1'b0;
            xlo = (cx - r < 0) ? 0 : cx - r;
            xhi = (cx + r > w - 1) ? w - 1 : cx + r;
            for (x = xlo; x <= xhi && !ring_skip; x++) begin
                dx = (x > cx) ? x - cx : cx - x;
                dy = r - dx;
                if (dy >= 0) begin
                    for (k = 0; k < 2 && !ring_skip; k++) begin
                        y = (k == 0) ? cy - dy : cy + dy;
                        if ((k == 0 || dy > 0) && y >= 0 && y < h) begin
                            d = depth_mirror.exists(y * MAX_WIDTH + x) ?
                                depth_mirror[y * MAX_WIDTH + x] : '0;
                            if (d != '0) begin
                                // pixel at index zero ends the ring without a match
                                if (x == 0 && y == 0) begin
                                    ring_skip = 1'b1;
                                end else begin
                                    res.found = 1'b1;
                                    res.match_x = X_W'(x);
                                    res.match_y = Y_W'(y);
                                    res.match_index = IDX_W'(x + y * w);
                                    res.match_depth = d;
                                    return res;
                                end
                            end
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // true when every pixel a query might probe has been written
    function automatic bit area_written(int cx, int cy);
        int w, h, rmax, x, y, dx;
        w = clip_to(reg_width, MAX_WIDTH);
        h = clip_to(reg_height, MAX_HEIGHT);
        rmax = clip_to(reg_radius, RADIUS_LIMIT);
        if (w == 0 || h == 0) return 1'b1;
        for (x = (cx - rmax < 0) ? 0 : cx - rmax; x <= cx + rmax && x < w; x++) begin
            dx = (x > cx) ? x - cx : cx - x;
            for (y = cy - (rmax - dx); y <= cy + (rmax - dx); y++) begin
                if (y >= 0 && y < h && !depth_mirror.exists(y * MAX_WIDTH + x))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [D_W-1:0] pick_depth();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return '0;
        if (roll < 45) return '1;
        return D_W'($urandom_range(1, 65535));
    endfunction

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got %p", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_matches.pop_front();
                check_field("found", want.found, m_data.found);
                check_field("match_x", want.match_x, m_data.match_x);
                check_field("match_y", want.match_y, m_data.match_y);
                check_field("match_index", want.match_index, m_data.match_index);
                check_field("match_depth", want.match_depth, m_data.match_depth);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic put_item(input nvd_in_t item);
        while (!no_gaps && $urandom_range(0, 99) < 16) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = item;
        do @(posedge aclk); while (!s_ready);
        if (item.mode == MODE_QUERY)
            pending_matches = {pending_matches, nearest_valid(item.pixel_x, item.pixel_y)};
        else
            depth_mirror[item.pixel_y * MAX_WIDTH + item.pixel_x] = item.depth_value;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic store_depth(input int x, input int y, input logic [D_W-1:0] d);
        nvd_in_t item;
        item.mode = MODE_WRITE;
        item.pixel_x = X_W'(x);
        item.pixel_y = Y_W'(y);
        item.depth_value = d;
        put_item(item);
    endtask

    task automatic ask_nearest(input int x, input int y, output bit sent);
        nvd_in_t item;
        sent = area_written(x, y);
        if (!sent) return;
        item.mode = MODE_QUERY;
        item.pixel_x = X_W'(x);
        item.pixel_y = Y_W'(y);
        item.depth_value = D_W'($urandom);
        put_item(item);
    endtask

    // trailing writes may still sit in the queue after the last result
    task automatic settle();
        while (pending_matches.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CW_W-1:0] value);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:   reg_width = value;
            CFG_IMAGE_HEIGHT:  reg_height = value[CH_W-1:0];
            CFG_SEARCH_RADIUS: reg_radius = value[CR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        bit ok;
        // centre far right of the 640 wide frame: every ring clips away
        ask_nearest(1023, 511, ok);
    endtask

    task automatic test_small_frame_rules();
        bit ok;
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 10'd2);
        write_reg(CFG_SEARCH_RADIUS, 11'd2);
        store_depth(0, 0, 16'hFFFF);
        store_depth(1, 0, 16'h0000);
        store_depth(2, 0, 16'h0000);
        store_depth(0, 1, 16'h0000);
        store_depth(1, 1, 16'h0000);
        store_depth(2, 1, 16'h0001);
        // from (0,0) only the origin is valid within reach: nothing found
        ask_nearest(0, 0, ok);
        ask_nearest(2, 1, ok);
        // origin skipped on ring 1, match found on ring 2
        ask_nearest(1, 0, ok);
        store_depth(1023, 511, 16'hFFFF);
        store_depth(1, 1, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        bit ok;
        write_reg(CFG_IMAGE_WIDTH, 11'd0);
        ask_nearest(0, 0, ok);
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 10'd0);
        ask_nearest(1, 1, ok);
        write_reg(CFG_IMAGE_HEIGHT, 10'd2);
        write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
        write_reg(CFG_SEARCH_RADIUS, 11'd1);
        ask_nearest(1, 1, ok);
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, 10'h3FF);
        ask_nearest(1, 0, ok);
        write_reg(CFG_SEARCH_RADIUS, {7'h7F, 4'd0});
        ask_nearest(2, 1, ok);
        write_reg(CFG_UNUSED, CW_W'($urandom));
        ask_nearest(0, 1, ok);
    endtask

    // fill the block (x0,y0,bw,bh) then mix writes and queries, most of them around it
    task automatic run_phase(input logic [CW_W-1:0] w_reg, input logic [CH_W-1:0] h_reg,
                             input logic [CR_W-1:0] rad, input int x0, input int y0,
                             input int bw, input int bh, input int count);
        int sent, roll, qx, qy, x, y;
        bit ok;
        write_reg(CFG_IMAGE_WIDTH, w_reg);
        write_reg(CFG_IMAGE_HEIGHT, CW_W'(h_reg));
        write_reg(CFG_SEARCH_RADIUS, {7'($urandom), rad});
        for (y = y0; y < y0 + bh; y++)
            for (x = x0; x < x0 + bw; x++)
                store_depth(x, y, pick_depth());
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                store_depth(x0 + $urandom_range(0, bw - 1), y0 + $urandom_range(0, bh - 1),
                            pick_depth());
                sent++;
            end else if (roll < 55) begin
                store_depth($urandom_range(0, 1023), $urandom_range(0, 511),
                            D_W'($urandom));
                sent++;
            end else begin
                if (roll < 92) begin
                    qx = x0 - 3 + $urandom_range(0, bw + 5);
                    qy = y0 - 3 + $urandom_range(0, bh + 5);
                    qx = (qx < 0) ? 0 : clip_to(qx, 1023);
                    qy = (qy < 0) ? 0 : clip_to(qy, 511);
                end else begin
                    qx = $urandom_range(0, 1023);
                    qy = $urandom_range(0, 511);
                end
                ask_nearest(qx, qy, ok);
                if (ok) sent++;
            end
        end
    endtask

    task automatic test_random_frames();
        run_phase(11'd8, 10'd6, 4'd15, 0, 0, 8, 6, 120);
        run_phase(11'd1, 10'd12, 4'd0, 0, 0, 1, 12, 110);
        no_gaps = 1'b1;
        run_phase(11'd12, 10'd9, CR_W'($urandom_range(1, 14)), 0, 0, 12, 9, 150);
        no_gaps = 1'b0;
        run_phase(11'd5, 10'd16, 4'd7, 0, 0, 5, 16, 120);
        // oversized registers clamp to the full frame; work in the far corner
        run_phase(11'h7FF, 10'h3FF, 4'd4, 1016, 504, 8, 8, 150);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_small_frame_rules();
        test_register_extremes();
        test_random_frames();
        settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
